>>> rtl/core/http_chunked_body_decoder_defines.svh
// Assertion macros used by the decoder top, the one file that checks its own logic.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define HCBD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("hcbd check failed");
`define HCBD_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("hcbd forbidden condition");
`else
`define HCBD_ASSERT(lbl, clk, rst_n, prop)
`define HCBD_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> rtl/core/hcbd_pkg.sv
`default_nettype none
package hcbd_pkg;

	localparam int COUNT_WIDTH_DEF = 32;

	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_LF = 8'h0A;

	typedef enum logic [2:0] {
		PH_SIZE    = 3'd0,
		PH_DATA    = 3'd1,
		PH_SKIP1   = 3'd2,
		PH_SKIP2   = 3'd3,
		PH_TRAILER = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FRAME = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_LAST  = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	typedef struct packed {
		phase_t phase;
		logic   prev_was_cr;
		logic   digits_done;
	} ctl_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload;
	} res_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] nibble;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.is_hex = 1'b1;
		h.nibble = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.nibble = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.nibble = 4'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.nibble = 4'(c - 8'h61 + 8'd10);
		end else begin
			h.is_hex = 1'b0;
		end
		return h;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/hcbd_step.sv
`default_nettype none
module hcbd_step import hcbd_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire ctl_t                   ctl,
	input  wire logic [COUNT_WIDTH-1:0] count,
	input  wire logic [7:0]             data_byte,
	output ctl_t                        ctl_nxt,
	output logic [COUNT_WIDTH-1:0]      count_nxt,
	output res_t                        res
);

	hex_t hx;
	logic ends_line;
	logic last_byte;

	assign hx        = hex_value(data_byte);
	assign ends_line = (data_byte == BYTE_LF) && ctl.prev_was_cr;
	assign last_byte = (count[COUNT_WIDTH-1:1] == '0);

	// next state
	always_comb begin
		ctl_nxt   = ctl;
		count_nxt = count;
		case (ctl.phase)
			PH_DATA: begin
				if (last_byte) begin
					count_nxt     = '0;
					ctl_nxt.phase = PH_SKIP1;
				end else begin
					count_nxt = count - COUNT_WIDTH'(1);
				end
			end
			PH_SKIP1: begin
				ctl_nxt.phase = PH_SKIP2;
			end
			PH_SKIP2: begin
				ctl_nxt.phase       = PH_SIZE;
				count_nxt           = '0;
				ctl_nxt.prev_was_cr = 1'b0;
				ctl_nxt.digits_done = 1'b0;
			end
			PH_TRAILER: begin
				ctl_nxt.prev_was_cr = (data_byte == BYTE_CR) && !ends_line;
				if (ends_line) begin
					ctl_nxt.phase       = PH_SIZE;
					count_nxt           = '0;
					ctl_nxt.digits_done = 1'b0;
				end
			end
			default: begin
				ctl_nxt.phase       = PH_SIZE;
				ctl_nxt.prev_was_cr = (data_byte == BYTE_CR) && !ends_line;
				if (ends_line) begin
					ctl_nxt.digits_done = 1'b0;
					ctl_nxt.phase       = (count == '0) ? PH_TRAILER : PH_DATA;
				end else if (!ctl.digits_done) begin
					if (!hx.is_hex) begin
						ctl_nxt.digits_done = 1'b1;
					end else begin
						count_nxt = {count[COUNT_WIDTH-5:0], hx.nibble};
					end
				end
			end
		endcase
	end

	// result
	always_comb begin
		res.kind    = KIND_FRAME;
		res.payload = 8'd0;
		case (ctl.phase)
			PH_DATA: begin
				res.kind    = last_byte ? KIND_LAST : KIND_DATA;
				res.payload = data_byte;
			end
			PH_TRAILER: begin
				if (ends_line) begin
					res.kind = KIND_DONE;
				end
			end
			default: begin
				res.kind = KIND_FRAME;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/hcbd_out_reg.sv
`default_nettype none
module hcbd_out_reg import hcbd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t push_res,
	output logic      push_ready,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output res_t      pop_res
);

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;
	logic main_free;

	assign main_free  = pop_ready || !main_valid_q;
	assign push_ready = !skid_valid_q;
	assign pop_valid  = main_valid_q;
	assign pop_res    = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/http_chunked_body_decoder.sv
// channel  | handshake                  | payload
// ---------+----------------------------+--------------
// input    | byte_valid / byte_ready    | data_byte
// output   | result_valid / result_ready| kind, payload
//
// One item per cycle while byte_ready is high; a result appears the cycle after
// its item is taken, later when an earlier result is held back by result_ready.
// Decode state updates at acceptance; a two-entry output register holds results.
// byte_ready drops only when both output entries are full.
// arst_n clears phase, count, line flags and both output valids.
`default_nettype none
`include "http_chunked_body_decoder_defines.svh"
module http_chunked_body_decoder import hcbd_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire logic [7:0] data_byte,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [1:0]      kind,
	output logic [7:0]      payload
);

	ctl_t                   ctl_q;
	ctl_t                   ctl_nxt;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_nxt;
	res_t                   step_res;
	res_t                   out_res;
	logic                   take;

	assign take = byte_valid && byte_ready;

	hcbd_step #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_step (
		.ctl      (ctl_q),
		.count    (count_q),
		.data_byte(data_byte),
		.ctl_nxt  (ctl_nxt),
		.count_nxt(count_nxt),
		.res      (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase       <= PH_SIZE;
			ctl_q.prev_was_cr <= 1'b0;
			ctl_q.digits_done <= 1'b0;
			count_q           <= '0;
		end else if (take) begin
			ctl_q   <= ctl_nxt;
			count_q <= count_nxt;
		end
	end

	hcbd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_res  (step_res),
		.push_ready(byte_ready),
		.pop_valid (result_valid),
		.pop_ready (result_ready),
		.pop_res   (out_res)
	);

	assign kind    = out_res.kind;
	assign payload = out_res.payload;

	`HCBD_NEVER(a_data_nonzero, clk, arst_n, ctl_q.phase == PH_DATA && count_q == '0)
	`HCBD_ASSERT(a_stall_has_result, clk, arst_n, !byte_ready |-> result_valid)
	`HCBD_ASSERT(a_skip_order, clk, arst_n, take && ctl_q.phase == PH_SKIP1 |=> ctl_q.phase == PH_SKIP2)
	`HCBD_ASSERT(a_last_to_skip, clk, arst_n, take && ctl_q.phase == PH_DATA && count_q == COUNT_WIDTH'(1) |=> ctl_q.phase == PH_SKIP1)

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
	import hcbd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = COUNT_WIDTH_DEF;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_ready;
	logic [7:0] data_byte = 8'h00;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] payload;

	http_chunked_body_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.data_byte(data_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.kind(kind),
		.payload(payload)
	);

	// decoder state as predicted from the accepted bytes
	phase_t          ph = PH_SIZE;
	logic [CW-1:0]   chunk_count = '0;
	bit              saw_cr = 1'b0;
	bit              count_closed = 1'b0;

	res_t            pending_results[$];
	int unsigned     tx_idle_pct = 0;
	int unsigned     rx_idle_pct = 0;
	int unsigned     bytes_sent = 0;
	int unsigned     results_seen = 0;
	int unsigned     bodies_done = 0;
	int unsigned     errors = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic res_t frame_byte(input logic [7:0] c);
		res_t     r;
		bit       ends;
		bit       is_hex;
		logic [3:0] digit;
		r.kind = KIND_FRAME;
		r.payload = 8'h00;
		ends = (c == BYTE_LF) && saw_cr;
		is_hex = 1'b1;
		digit = 4'd0;
		case (ph)
			PH_DATA: begin
				r.payload = c;
				if (chunk_count <= 1) begin
					r.kind = KIND_LAST;
					chunk_count = '0;
					ph = PH_SKIP1;
				end else begin
					r.kind = KIND_DATA;
					chunk_count = chunk_count - 1'b1;
				end
			end
			PH_SKIP1: ph = PH_SKIP2;
			PH_SKIP2: begin
				ph = PH_SIZE;
				chunk_count = '0;
				saw_cr = 1'b0;
				count_closed = 1'b0;
			end
			PH_TRAILER: begin
				saw_cr = (c == BYTE_CR);
				if (ends) begin
					r.kind = KIND_DONE;
					ph = PH_SIZE;
					chunk_count = '0;
					count_closed = 1'b0;
				end
			end
			default: begin
				saw_cr = (c == BYTE_CR);
				if (ends) begin
					count_closed = 1'b0;
					ph = (chunk_count == 0) ? PH_TRAILER : PH_DATA;
				end else if (!count_closed) begin
					if (c >= 8'h30 && c <= 8'h39)
						digit = c[3:0];
					else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
						digit = c[3:0] + 4'd9;
					else
						is_hex = 1'b0;
					if (is_hex)
						chunk_count = (chunk_count << 4) | CW'(digit);
					else
						count_closed = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		if (d < 10)
			return 8'h30 + d;
		return ($urandom_range(1) ? 8'h61 : 8'h41) + d - 8'd10;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!byte_ready);
		pending_results.push_back(frame_byte(b));
		bytes_sent++;
	endtask

	task automatic send_crlf();
		send_byte(BYTE_CR);
		send_byte(BYTE_LF);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_size_line(input int unsigned v);
		int nd;
		if (v != 0 || $urandom_range(9) != 0) begin
			if (v < 16 && $urandom_range(7) == 0) begin
				// digits above the low 32 bits fall away
				repeat ($urandom_range(1, 3)) send_byte(hex_char(4'($urandom_range(1, 15))));
				repeat (7) send_byte(8'h30);
				send_byte(hex_char(4'(v)));
			end else begin
				repeat ($urandom_range(2)) send_byte(8'h30);
				nd = 1;
				while (nd < 8 && (v >> (4 * nd)) != 0)
					nd++;
				for (int i = nd - 1; i >= 0; i--)
					send_byte(hex_char(4'(v >> (4 * i))));
			end
		end
		if ($urandom_range(3) == 0) begin
			send_byte($urandom_range(1) ? 8'h3b : 8'h20);
			repeat ($urandom_range(4)) send_byte(8'($urandom_range(8'h20, 8'h7e)));
		end
		if ($urandom_range(7) == 0)
			send_byte(BYTE_CR);
		send_crlf();
	endtask

	task automatic send_body();
		int unsigned len;
		repeat ($urandom_range(3)) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
			send_size_line(len);
			repeat (len) send_byte(8'($urandom_range(255)));
			if ($urandom_range(4) == 0) begin
				send_byte(8'($urandom_range(255)));
				send_byte(8'($urandom_range(255)));
			end else begin
				send_crlf();
			end
		end
		send_size_line(0);
		repeat ($urandom_range(5)) send_byte(8'($urandom_range(8'h20, 8'h7e)));
		send_crlf();
	endtask

	// advance the stream until the decoder sits at the start of a clean size line
	task automatic sync_to_size_line();
		while (!(ph == PH_SIZE && chunk_count == 0 && !count_closed)) begin
			if (ph == PH_SIZE || ph == PH_TRAILER)
				send_crlf();
			else
				send_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic wait_for_drain();
		byte_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_text("100000002");
		send_crlf();
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h80);
		send_byte(8'h7f);
		send_crlf();
		send_text("t");
		send_byte(BYTE_CR);
		send_crlf();
		send_text("0;e");
		send_crlf();
		send_crlf();
	endtask

	task automatic test_pause_mid_chunk();
		send_text("3");
		send_crlf();
		send_text("a");
		wait_for_drain();
		send_text("bc");
		send_crlf();
		send_text("0");
		send_crlf();
		send_crlf();
	endtask

	task automatic test_random_bodies(input int unsigned n);
		int unsigned stop_at;
		int unsigned sel;
		int unsigned len;
		stop_at = bytes_sent + n;
		while (bytes_sent < stop_at) begin
			sync_to_size_line();
			sel = $urandom_range(99);
			if (sel < 80) begin
				send_body();
			end else if (sel < 90) begin
				len = $urandom_range(2, 8);
				send_size_line(len);
				repeat ($urandom_range(len - 1)) send_byte(8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result with no item pending: kind %0d payload %0h", kind, payload);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (kind != want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						errors++;
					end
					if (payload != want.payload) begin
						$error("payload: expected %02h, got %02h", want.payload, payload);
						errors++;
					end
					if (want.kind == KIND_DONE)
						bodies_done++;
				end
			end
			result_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 34;
		rx_idle_pct = 83;
		test_directed();
		test_pause_mid_chunk();
		test_random_bodies(320);

		tx_idle_pct = 83;
		rx_idle_pct = 34;
		test_random_bodies(320);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_bodies(320);

		byte_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Fed %0d body bytes (chunked bodies, cut chunks, stray bytes) under three stall mixes;",
			bytes_sent);
		$display("compared %0d results, %0d of them message completions.", results_seen, bodies_done);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
